FILE: design/smms_pkg.sv
// shared types and constants for the spi mode 0 shifter
package smms_pkg;

  localparam int unsigned MAX_WORD_BITS_DEF = 16;
  localparam int unsigned TX_BITS           = 16;
  localparam int unsigned RX_BITS           = 16;
  localparam int unsigned QUEUE_DEPTH       = 2;

  typedef enum logic {
    ACT_TICK  = 1'b0,
    ACT_START = 1'b1
  } act_e;

  typedef enum logic [1:0] {
    LEN_8   = 2'd0,
    LEN_9   = 2'd1,
    LEN_MAX = 2'd2
  } len_code_e;

  typedef struct packed {
    act_e               action;
    logic [TX_BITS-1:0] tx;
    len_code_e          len;
    logic               miso;
  } cmd_t;

endpackage

FILE: design/smms_front.sv
// front end: takes input transactions and decodes them into commands
module smms_front (
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  input  logic                 action_i,
  input  logic [15:0]          tx_word_i,
  input  logic [1:0]           word_size_i,
  input  logic                 miso_level_i,
  output logic                 push_o,
  output smms_pkg::cmd_t       cmd_o,
  input  logic                 q_full_i
);
  import smms_pkg::*;

  assign in_stall_o = q_full_i;
  assign push_o     = in_valid_i && !q_full_i;

  always_comb begin
    cmd_o.action = action_i ? ACT_START : ACT_TICK;
    cmd_o.tx     = tx_word_i;
    cmd_o.miso   = miso_level_i;
    // the unused size code falls back to the longest word
    unique case (word_size_i)
      2'd0:    cmd_o.len = LEN_8;
      2'd1:    cmd_o.len = LEN_9;
      default: cmd_o.len = LEN_MAX;
    endcase
  end

endmodule

FILE: design/smms_queue.sv
// short command queue between front and back end
module smms_queue (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_i,
  input  smms_pkg::cmd_t push_cmd_i,
  output logic           full_o,
  output logic           valid_o,
  input  logic           pop_i,
  output smms_pkg::cmd_t head_o
);
  import smms_pkg::*;

  localparam int unsigned PtrW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int unsigned CntW = $clog2(QUEUE_DEPTH + 1);

  cmd_t            mem_q [QUEUE_DEPTH];
  logic [PtrW-1:0] wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0] rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0] count_q, count_d;
  logic            do_push, do_pop;

  assign full_o  = (count_q == CntW'(QUEUE_DEPTH));
  assign valid_o = (count_q != '0);
  assign head_o  = mem_q[rd_ptr_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && valid_o;

  function automatic logic [PtrW-1:0] ptr_inc(input logic [PtrW-1:0] p);
    ptr_inc = (p == PtrW'(QUEUE_DEPTH - 1)) ? '0 : p + PtrW'(1);
  endfunction

  always_comb begin
    wr_ptr_d = do_push ? ptr_inc(wr_ptr_q) : wr_ptr_q;
    rd_ptr_d = do_pop ? ptr_inc(rd_ptr_q) : rd_ptr_q;
    count_d  = count_q;
    if (do_push && !do_pop) begin
      count_d = count_q + CntW'(1);
    end else if (do_pop && !do_push) begin
      count_d = count_q - CntW'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= push_cmd_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

endmodule

FILE: design/smms_back.sv
// back end: shift engine state and registered result
module smms_back #(
  parameter int unsigned MAX_WORD_BITS = smms_pkg::MAX_WORD_BITS_DEF
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           cfg_we_i,
  input  logic           cfg_wdata_i,
  input  logic           q_valid_i,
  input  smms_pkg::cmd_t q_head_i,
  output logic           q_pop_o,
  output logic           out_valid_o,
  input  logic           out_stall_i,
  output logic           mosi_o,
  output logic           sck_o,
  output logic           busy_res_o,
  output logic           done_res_o,
  output logic [15:0]    rx_word_o
);
  import smms_pkg::*;

  localparam int unsigned W     = MAX_WORD_BITS;
  localparam int unsigned BlW   = $clog2(W + 1);
  localparam int unsigned WideW = (W > TX_BITS) ? W : TX_BITS;

  logic           miso_en_q;
  logic [W-1:0]   shift_q, shift_d;
  logic [BlW-1:0] bits_left_q, bits_left_d;
  logic           clk_high_q, clk_high_d;
  logic           mosi_q, mosi_d;
  len_code_e      len_q, len_d;

  logic               res_valid_q;
  logic               res_mosi_q, res_sck_q, res_busy_q, res_done_q;
  logic [RX_BITS-1:0] res_rx_q;

  logic               busy;
  logic               done;
  logic [RX_BITS-1:0] rx;
  logic [WideW-1:0]   tx_wide, shift_wide;
  logic [W-1:0]       load_word;

  function automatic logic [W-1:0] len_mask(input len_code_e c);
    unique case (c)
      LEN_8:   len_mask = W'(9'h0FF);
      LEN_9:   len_mask = W'(9'h1FF);
      default: len_mask = '1;
    endcase
  endfunction

  function automatic logic top_bit(input logic [W-1:0] s, input len_code_e c);
    unique case (c)
      LEN_8:   top_bit = s[7];
      LEN_9:   top_bit = s[8];
      default: top_bit = s[W-1];
    endcase
  endfunction

  function automatic logic [BlW-1:0] len_bits(input len_code_e c);
    unique case (c)
      LEN_8:   len_bits = BlW'(8);
      LEN_9:   len_bits = BlW'(9);
      default: len_bits = BlW'(W);
    endcase
  endfunction

  assign busy       = (bits_left_q != '0) || clk_high_q;
  assign q_pop_o    = q_valid_i && (!res_valid_q || !out_stall_i);
  assign tx_wide    = WideW'(q_head_i.tx);
  assign load_word  = tx_wide[W-1:0] & len_mask(q_head_i.len);
  assign shift_wide = WideW'(shift_q);

  always_comb begin
    shift_d     = shift_q;
    bits_left_d = bits_left_q;
    clk_high_d  = clk_high_q;
    mosi_d      = mosi_q;
    len_d       = len_q;
    done        = 1'b0;
    rx          = '0;
    if (q_head_i.action == ACT_START) begin
      // a start during a transfer leaves everything alone
      if (!busy) begin
        len_d       = q_head_i.len;
        shift_d     = load_word;
        bits_left_d = len_bits(q_head_i.len);
        clk_high_d  = 1'b0;
        mosi_d      = top_bit(load_word, q_head_i.len);
      end
    end else if (busy) begin
      if (!clk_high_q) begin
        // rising half: sample miso into the low bit
        clk_high_d  = 1'b1;
        shift_d     = ((shift_q << 1) | W'(q_head_i.miso & miso_en_q)) & len_mask(len_q);
        bits_left_d = bits_left_q - BlW'(1);
      end else begin
        clk_high_d = 1'b0;
        if (bits_left_q == '0) begin
          done = 1'b1;
          rx   = shift_wide[RX_BITS-1:0];
        end else begin
          mosi_d = top_bit(shift_q, len_q);
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      miso_en_q   <= 1'b0;
      shift_q     <= '0;
      bits_left_q <= '0;
      clk_high_q  <= 1'b0;
      mosi_q      <= 1'b0;
      len_q       <= LEN_8;
      res_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        miso_en_q <= cfg_wdata_i;
      end
      if (q_pop_o) begin
        shift_q     <= shift_d;
        bits_left_q <= bits_left_d;
        clk_high_q  <= clk_high_d;
        mosi_q      <= mosi_d;
        len_q       <= len_d;
        res_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        res_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (q_pop_o) begin
      res_mosi_q <= mosi_d;
      res_sck_q  <= clk_high_d;
      res_busy_q <= (bits_left_d != '0) || clk_high_d;
      res_done_q <= done;
      res_rx_q   <= rx;
    end
  end

  assign out_valid_o = res_valid_q;
  assign mosi_o      = res_mosi_q;
  assign sck_o       = res_sck_q;
  assign busy_res_o  = res_busy_q;
  assign done_res_o  = res_done_q;
  assign rx_word_o   = res_rx_q;

  a_bits_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    bits_left_q <= BlW'(W))
    else $error("bit counter beyond word length");

  a_done_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_valid_q && res_done_q) |-> (!res_busy_q && !res_sck_q))
    else $error("done reported while transfer still running");

  a_sck_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_valid_q && res_sck_q) |-> res_busy_q)
    else $error("sck high outside a transfer");

  a_rx_quiet: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_valid_q && !res_done_q) |-> (res_rx_q == '0))
    else $error("received word given without done");

  a_hold_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_valid_q && out_stall_i) |=> (res_valid_q && $stable(res_rx_q)))
    else $error("stalled result lost");

endmodule

FILE: design/spi_master_mode0_shifter_unit.sv
// top level of the spi mode 0 shift engine
// Each transaction on the input channel is a start (loads a word of 8, 9 or MAX_WORD_BITS bits,
// msb first) or a half-period tick of sck; every input transaction yields exactly one output
// transaction carrying the mosi and sck levels, busy, done and, with done, the received word.
// One transaction is taken per clock cycle when the output side keeps up; a result passes through
// the two-entry command queue and then the shift engine, whose state update and result register
// close in the same cycle. The queue lets the input keep flowing for a short while when the output
// stalls. miso_enable is written through cfg_we_i; the user must write it only while the engine is
// idle, which the block itself does not enforce; with it clear zeros are shifted in.
module spi_master_mode0_shifter_unit #(
  parameter int unsigned MAX_WORD_BITS = smms_pkg::MAX_WORD_BITS_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic        cfg_wdata_i,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic        action_i,
  input  logic [15:0] tx_word_i,
  input  logic [1:0]  word_size_i,
  input  logic        miso_level_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic        mosi_o,
  output logic        sck_o,
  output logic        busy_res_o,
  output logic        done_res_o,
  output logic [15:0] rx_word_o
);
  import smms_pkg::*;

  cmd_t push_cmd, head_cmd;
  logic push, q_full, q_valid, q_pop;

  smms_front u_front (
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .action_i     (action_i),
    .tx_word_i    (tx_word_i),
    .word_size_i  (word_size_i),
    .miso_level_i (miso_level_i),
    .push_o       (push),
    .cmd_o        (push_cmd),
    .q_full_i     (q_full)
  );

  smms_queue u_queue (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (push),
    .push_cmd_i (push_cmd),
    .full_o     (q_full),
    .valid_o    (q_valid),
    .pop_i      (q_pop),
    .head_o     (head_cmd)
  );

  smms_back #(
    .MAX_WORD_BITS (MAX_WORD_BITS)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .q_valid_i   (q_valid),
    .q_head_i    (head_cmd),
    .q_pop_o     (q_pop),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .mosi_o      (mosi_o),
    .sck_o       (sck_o),
    .busy_res_o  (busy_res_o),
    .done_res_o  (done_res_o),
    .rx_word_o   (rx_word_o)
  );

endmodule
